// ----- hw/rtl/spq_pkg.sv -----
// Shared types and constants for the sorted priority queue.
// No dependencies; imported by spq_cell and sorted_priority_queue.
package spq_pkg;

  localparam int CAPACITY = 8;
  localparam int DATA_W   = 32;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int OUT_CNT_W = 4;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;

  // Operation broadcast to every cell of the row.
  typedef struct packed {
    logic                     ins;
    logic                     rem;
    logic signed [DATA_W-1:0] value;
  } spq_op_t;

endpackage

// ----- hw/rtl/spq_cell.sv -----
// One slot of the sorted row: holds an entry and shifts with its neighbors.
// Depends on spq_pkg.
module spq_cell
  import spq_pkg::*;
(
  input  logic                     clk,
  input  spq_op_t                  op,
  input  logic                     occupied,
  input  logic                     left_before,
  input  logic signed [DATA_W-1:0] left_entry,
  input  logic signed [DATA_W-1:0] right_entry,
  output logic                     ahead,
  output logic signed [DATA_W-1:0] entry
);

  logic signed [DATA_W-1:0] entry_r;
  logic signed [DATA_W-1:0] entry_nxt;

  // Held entry sorts strictly ahead of the incoming value.
  assign ahead = occupied && (entry_r < op.value);
  assign entry = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    if (op.ins) begin
      if (!ahead) begin
        entry_nxt = left_before ? op.value : left_entry;
      end
    end else if (op.rem) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

// ----- hw/rtl/sorted_priority_queue.sv -----
// Sorted priority queue: a row of CAPACITY compare-and-shift cells.
// Result word is registered and valid in the cycle after the request is accepted.
// Throughput: one request per cycle while the result side is not stalled; every cell updates in parallel each cycle.
// Output register decouples the result side; input ready while it is free or draining.
// Reset clears the entry count and output valid; cell contents stay undefined.
module sorted_priority_queue
  import spq_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_req_type,
  input  logic signed [DATA_W-1:0]    in_value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [DATA_W-1:0]    out_removed_value,
  output logic [1:0]                  out_status,
  output logic                        out_now_empty,
  output logic [OUT_CNT_W-1:0]        out_entry_count
);

  logic [CNT_W-1:0]         count_r, count_nxt;
  logic                     out_valid_r;
  logic signed [DATA_W-1:0] removed_r;
  logic [1:0]               status_r;
  logic                     empty_r;
  logic [CNT_W-1:0]         res_count_r;

  logic    accept, full, empty;
  spq_op_t op;
  logic signed [DATA_W-1:0] entry  [CAPACITY];
  logic                     ahead  [CAPACITY];

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign full     = (count_r == CNT_W'(CAPACITY));
  assign empty    = (count_r == '0);

  assign op.ins   = accept && (in_req_type == REQ_INSERT) && !full;
  assign op.rem   = accept && (in_req_type == REQ_REMOVE) && !empty;
  assign op.value = in_value;

  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      logic                     lb;
      logic signed [DATA_W-1:0] le;
      logic signed [DATA_W-1:0] re;
      if (i == 0) begin : g_first
        // front cell: the value goes here unless the head sorts ahead of it
        assign lb = 1'b1;
        assign le = '0;
      end else begin : g_mid
        assign lb = ahead[i-1];
        assign le = entry[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
        assign re = '0;
      end else begin : g_inner
        assign re = entry[i+1];
      end
      spq_cell u_cell (
        .clk         (clk),
        .op          (op),
        .occupied    (count_r > CNT_W'(i)),
        .left_before (lb),
        .left_entry  (le),
        .right_entry (re),
        .ahead       (ahead[i]),
        .entry       (entry[i])
      );
    end
  endgenerate

  always_comb begin
    count_nxt = count_r;
    if (op.ins) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (op.rem) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      removed_r   <= op.rem ? entry[0] : '0;
      if (in_req_type == REQ_INSERT) begin
        status_r <= full ? ST_OVERFLOW : ST_DONE;
      end else begin
        status_r <= empty ? ST_UNDERFLOW : ST_DONE;
      end
      empty_r     <= (count_nxt == '0);
      res_count_r <= count_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_removed_value = removed_r;
  assign out_status        = status_r;
  assign out_now_empty     = empty_r;
  assign out_entry_count   = OUT_CNT_W'(res_count_r);

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
    op.ins |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("insert did not grow the count");

  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_OVERFLOW) |-> out_entry_count == OUT_CNT_W'(CAPACITY))
    else $error("overflow reported while not full");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_now_empty == (out_entry_count == '0)))
    else $error("empty flag disagrees with count");

endmodule
